[src/peak_window_gain_control_unit_assert.svh]
// Assertion macros shared by the peak window gain control RTL.
`ifndef PEAK_WINDOW_GAIN_CONTROL_UNIT_ASSERT_SVH
`define PEAK_WINDOW_GAIN_CONTROL_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PWGC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PWGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pwgc_pkg.sv]
// Types and constants of the peak window gain control unit.
`timescale 1ns / 1ps
`default_nettype none

package pwgc_pkg;

  typedef logic [15:0] q412_t;

  localparam int unsigned CFG_INDEX_W = 3;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_NOISE_THRESHOLD = 3'd0;
  localparam cfg_index_t REG_TARGET_LEVEL    = 3'd1;
  localparam cfg_index_t REG_INCREMENT_STEP  = 3'd2;
  localparam cfg_index_t REG_DECREMENT_STEP  = 3'd3;
  localparam cfg_index_t REG_MIN_GAIN        = 3'd4;
  localparam cfg_index_t REG_MAX_GAIN        = 3'd5;

  typedef struct packed {
    q412_t noise_threshold;
    q412_t target_level;
    q412_t increment_step;
    q412_t decrement_step;
    q412_t min_gain;
    q412_t max_gain;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    noise_threshold: 16'd410,
    target_level:    16'd3686,
    increment_step:  16'd68,
    decrement_step:  16'd205,
    min_gain:        16'd2048,
    max_gain:        16'd20480
  };

  localparam q412_t GAIN_ONE = 16'd4096;

  // Flux in Q20.4 divided by 8000 gives Q4.12 as (flux * 4) / 125.
  localparam q412_t FLUX_DIVISOR = 16'd125;

  // Serial divider: 28-bit dividend, one quotient bit per cycle.
  localparam int unsigned DIV_W     = 28;
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd27;

endpackage

`default_nettype wire

[src/peak_window_gain_control_unit.sv]
// Top level of the peak window gain control unit.
//
//  Channel  Direction  Beat contents
//  -------  ---------  -----------------------------------------------------
//  in_      slave      tdata: peak_magnitude, spectral_flux; tuser: has_flux
//  out_     master     tdata: spectrum_gain, flux_gain; tuser: gain_held
//  cfg_     slave      cfg_index selects a register, cfg_data is its value
//
// An input beat with a flux value runs the scaling division, the ring write,
// the window scan, then for each gain a check, a division and a gain step, and
// the output once the output register is free; a held gain skips its division
// and gain step. Without flux the scaling division and the whole flux update
// drop out. The scan reads one ring entry per cycle over the entries filled so
// far, and up to three divisions per beat run on the bit-serial divider.
// Reset is synchronous and active low; it clears the flux ring by its valid
// bits at once, so no clearing pass is needed. The output register holds a
// result until out_tready takes it while the next beat is already accepted.
// Configuration beats are taken in every cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "peak_window_gain_control_unit_assert.svh"

module peak_window_gain_control_unit #(
  parameter int unsigned WINDOW_LEN = 40
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Input frames.
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [39:0]                 in_tdata,   // [15:0] peak_magnitude,
                                                       // [39:16] spectral_flux
  input  wire logic                        in_tuser,   // [0] has_flux
  // Results.
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [31:0]                      out_tdata,  // [15:0] spectrum_gain,
                                                       // [31:16] flux_gain
  output logic                             out_tuser,  // [0] gain_held
  // Configuration writes.
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [pwgc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                 cfg_data
);

  localparam int unsigned AW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned FW = $clog2(WINDOW_LEN + 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(WINDOW_LEN - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_LEN);

  // Controller state codes.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_STEPA = 3'd5;
  localparam logic [2:0] S_STEPB = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  // What the shared divider and gain step are working on.
  localparam logic [1:0] PH_SCALE = 2'd0;
  localparam logic [1:0] PH_SPEC  = 2'd1;
  localparam logic [1:0] PH_FLUX  = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  pwgc_pkg::cfg_regs_t cfg_r, cfg_nxt;

  // Captured frame.
  pwgc_pkg::q412_t peak_r, peak_nxt;
  logic            hasf_r, hasf_nxt;

  // Ring bookkeeping.
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] fhead_r, fhead_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  // Window scan.
  logic [FW-1:0]   k_r, k_nxt;
  logic [AW-1:0]   faddr_r, faddr_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  pwgc_pkg::q412_t pmax_r, pmax_nxt;
  pwgc_pkg::q412_t fmax_r, fmax_nxt;
  logic            scan_rd_en;

  // Bit-serial restoring divider.
  logic [15:0]                       rem_r, rem_nxt;
  logic [pwgc_pkg::DIV_W-1:0]        quo_r, quo_nxt;
  pwgc_pkg::q412_t                   dvs_r, dvs_nxt;
  logic [pwgc_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [16:0]                       div_trial;
  logic [16:0]                       div_diff;
  logic                              div_ge;

  // Gain step.
  logic [16:0]     cand_r, cand_nxt;
  logic            fall_r, fall_nxt;
  pwgc_pkg::q412_t sgain_r, sgain_nxt;
  pwgc_pkg::q412_t fgain_r, fgain_nxt;
  logic            held_r, held_nxt;
  pwgc_pkg::q412_t cur_gain;
  pwgc_pkg::q412_t cur_wmax;
  logic            wmax_low;
  logic [16:0]     gain_minus;
  logic [16:0]     gain_plus;
  pwgc_pkg::q412_t step_res;
  pwgc_pkg::q412_t flux_scaled;

  // Output register.
  logic            out_valid_r, out_valid_nxt;
  pwgc_pkg::q412_t out_sg_r, out_sg_nxt;
  pwgc_pkg::q412_t out_fg_r, out_fg_nxt;
  logic            out_held_r, out_held_nxt;

  // Rings and their read registers.
  pwgc_pkg::q412_t peak_mem [WINDOW_LEN];
  pwgc_pkg::q412_t flux_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] fvalid_r;
  pwgc_pkg::q412_t peak_rd_r;
  pwgc_pkg::q412_t flux_rd_r;
  logic            fval_rd_r;
  logic            peak_wr_en;
  logic            flux_wr_en;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_fg_r, out_sg_r};
  assign out_tuser  = out_held_r;

  assign peak_wr_en  = (state_r == S_WRITE);
  assign flux_wr_en  = (state_r == S_WRITE) && hasf_r;
  assign scan_rd_en  = (state_r == S_SCAN) && (k_r < fill_r);
  assign flux_scaled = (|quo_r[pwgc_pkg::DIV_W-1:16]) ? 16'hFFFF : quo_r[15:0];

  // One divider step: shift the next dividend bit into the remainder.
  assign div_trial = {rem_r, quo_r[pwgc_pkg::DIV_W-1]};
  assign div_diff  = div_trial - {1'b0, dvs_r};
  assign div_ge    = (div_trial >= {1'b0, dvs_r});

  assign cur_gain   = (phase_r == PH_FLUX) ? fgain_r : sgain_r;
  assign cur_wmax   = (phase_r == PH_FLUX) ? fmax_r : pmax_r;
  assign wmax_low   = (cur_wmax < cfg_r.noise_threshold) || (cur_wmax == 16'd0);
  assign gain_minus = {1'b0, cur_gain} - {1'b0, cfg_r.decrement_step};
  assign gain_plus  = {1'b0, cur_gain} + {1'b0, cfg_r.increment_step};

  // Final clamp: a falling gain stays at or above min_gain, a rising one at or
  // below max_gain.
  always_comb begin
    if (fall_r) begin
      step_res = (cand_r[15:0] < cfg_r.min_gain) ? cfg_r.min_gain : cand_r[15:0];
    end else begin
      step_res = (cand_r < {1'b0, cfg_r.max_gain}) ? cand_r[15:0] : cfg_r.max_gain;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cfg_nxt       = cfg_r;
    peak_nxt      = peak_r;
    hasf_nxt      = hasf_r;
    head_nxt      = head_r;
    fhead_nxt     = fhead_r;
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    faddr_nxt     = faddr_r;
    rd_vld_nxt    = 1'b0;
    pmax_nxt      = pmax_r;
    fmax_nxt      = fmax_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    cand_nxt      = cand_r;
    fall_nxt      = fall_r;
    sgain_nxt     = sgain_r;
    fgain_nxt     = fgain_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r;
    out_sg_nxt    = out_sg_r;
    out_fg_nxt    = out_fg_r;
    out_held_nxt  = out_held_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        pwgc_pkg::REG_NOISE_THRESHOLD: cfg_nxt.noise_threshold = cfg_data;
        pwgc_pkg::REG_TARGET_LEVEL:    cfg_nxt.target_level    = cfg_data;
        pwgc_pkg::REG_INCREMENT_STEP:  cfg_nxt.increment_step  = cfg_data;
        pwgc_pkg::REG_DECREMENT_STEP:  cfg_nxt.decrement_step  = cfg_data;
        pwgc_pkg::REG_MIN_GAIN:        cfg_nxt.min_gain        = cfg_data;
        pwgc_pkg::REG_MAX_GAIN:        cfg_nxt.max_gain        = cfg_data;
        default: begin
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          peak_nxt = in_tdata[15:0];
          hasf_nxt = in_tuser;
          if (in_tuser) begin
            quo_nxt   = {2'b00, in_tdata[39:16], 2'b00};
            dvs_nxt   = pwgc_pkg::FLUX_DIVISOR;
            rem_nxt   = 16'd0;
            cnt_nxt   = '0;
            phase_nxt = PH_SCALE;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_DIV: begin
        rem_nxt = div_ge ? div_diff[15:0] : div_trial[15:0];
        quo_nxt = {quo_r[pwgc_pkg::DIV_W-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == pwgc_pkg::DIV_LAST) begin
          state_nxt = (phase_r == PH_SCALE) ? S_WRITE : S_STEPA;
        end
      end
      S_WRITE: begin
        head_nxt = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
        if (fill_r != FILL_FULL) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (hasf_r) begin
          fhead_nxt = (fhead_r == IDX_LAST) ? '0 : fhead_r + 1'b1;
          faddr_nxt = fhead_r;
        end else begin
          faddr_nxt = (fhead_r == '0) ? IDX_LAST : fhead_r - 1'b1;
        end
        k_nxt     = '0;
        pmax_nxt  = 16'd0;
        fmax_nxt  = 16'd0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (rd_vld_r) begin
          if (peak_rd_r > pmax_r) begin
            pmax_nxt = peak_rd_r;
          end
          if (fval_rd_r && (flux_rd_r > fmax_r)) begin
            fmax_nxt = flux_rd_r;
          end
        end
        if (scan_rd_en) begin
          k_nxt      = k_r + 1'b1;
          faddr_nxt  = (faddr_r == '0) ? IDX_LAST : faddr_r - 1'b1;
          rd_vld_nxt = 1'b1;
        end else if (!rd_vld_r) begin
          phase_nxt = PH_SPEC;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (phase_r == PH_SPEC) begin
          held_nxt = wmax_low;
        end
        if (wmax_low) begin
          if ((phase_r == PH_SPEC) && hasf_r) begin
            phase_nxt = PH_FLUX;
            state_nxt = S_CHK;
          end else begin
            state_nxt = S_OUT;
          end
        end else begin
          quo_nxt   = {cfg_r.target_level, 12'd0};
          dvs_nxt   = cur_wmax;
          rem_nxt   = 16'd0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_STEPA: begin
        // The required gain now sits in the quotient register.
        if ((quo_r[pwgc_pkg::DIV_W-1:16] == '0) && (quo_r[15:0] < cur_gain)) begin
          fall_nxt = 1'b1;
          if (gain_minus[16] || (gain_minus[15:0] < quo_r[15:0])) begin
            cand_nxt = {1'b0, quo_r[15:0]};
          end else begin
            cand_nxt = gain_minus;
          end
        end else begin
          fall_nxt = 1'b0;
          if ((quo_r[pwgc_pkg::DIV_W-1:17] == '0) && (quo_r[16:0] < gain_plus)) begin
            cand_nxt = quo_r[16:0];
          end else begin
            cand_nxt = gain_plus;
          end
        end
        state_nxt = S_STEPB;
      end
      S_STEPB: begin
        if (phase_r == PH_FLUX) begin
          fgain_nxt = step_res;
        end else begin
          sgain_nxt = step_res;
        end
        if ((phase_r == PH_SPEC) && hasf_r) begin
          phase_nxt = PH_FLUX;
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_sg_nxt    = sgain_r;
          out_fg_nxt    = fgain_r;
          out_held_nxt  = held_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and registers with defined reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_SCALE;
      cfg_r       <= pwgc_pkg::CFG_RESET;
      head_r      <= '0;
      fhead_r     <= '0;
      fill_r      <= '0;
      k_r         <= '0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      sgain_r     <= pwgc_pkg::GAIN_ONE;
      fgain_r     <= pwgc_pkg::GAIN_ONE;
      out_valid_r <= 1'b0;
      fvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cfg_r       <= cfg_nxt;
      head_r      <= head_nxt;
      fhead_r     <= fhead_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      rd_vld_r    <= rd_vld_nxt;
      cnt_r       <= cnt_nxt;
      sgain_r     <= sgain_nxt;
      fgain_r     <= fgain_nxt;
      out_valid_r <= out_valid_nxt;
      if (flux_wr_en) begin
        fvalid_r[fhead_r] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    peak_r     <= peak_nxt;
    hasf_r     <= hasf_nxt;
    faddr_r    <= faddr_nxt;
    pmax_r     <= pmax_nxt;
    fmax_r     <= fmax_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    cand_r     <= cand_nxt;
    fall_r     <= fall_nxt;
    held_r     <= held_nxt;
    out_sg_r   <= out_sg_nxt;
    out_fg_r   <= out_fg_nxt;
    out_held_r <= out_held_nxt;
  end

  // Peak ring: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (peak_wr_en) begin
      peak_mem[head_r] <= peak_r;
    end
    if (scan_rd_en) begin
      peak_rd_r <= peak_mem[k_r[AW-1:0]];
    end
  end

  // Flux ring; an entry whose valid bit is clear is left out of the flux maximum.
  always_ff @(posedge clk) begin
    if (flux_wr_en) begin
      flux_mem[fhead_r] <= flux_scaled;
    end
    if (scan_rd_en) begin
      flux_rd_r <= flux_mem[faddr_r];
      fval_rd_r <= fvalid_r[faddr_r];
    end
  end

  `PWGC_ASSERT_NEXT(a_flux_beat_scales, in_tvalid && in_tready && in_tuser,
                    (state_r == S_DIV) && (phase_r == PH_SCALE),
                    "flux beat did not start the scaling division")
  `PWGC_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= FILL_FULL,
                    "ring fill count ran past the window length")
  `PWGC_ASSERT_SAME(a_out_from_out_state, $rose(out_valid_r), $past(state_r) == S_OUT,
                    "result appeared outside the output state")
  `PWGC_ASSERT_SAME(a_div_remainder, state_r == S_DIV, rem_r < dvs_r,
                    "divider remainder not below divisor")

endmodule

`default_nettype wire
